[rtl/assert_macros.svh]
// Assertion helpers shared by the checker files.
// Each macro expands to one labeled concurrent assertion that is clocked on
// i_clk and disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define CHK_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent checked in the cycle after the antecedent.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/ptrt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrt_pkg
// Types, sizes and codes shared by the task release table and its cells.
// ----------------------------------------------------------------------------
package ptrt_pkg;

    localparam int MAX_SLOTS  = 8;
    localparam int RESULT_CAP = 8;
    localparam int IDX_W      = $clog2(MAX_SLOTS);
    localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
    localparam int NRES_W     = $clog2(RESULT_CAP + 1);

    // operation codes
    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_TICK     = 2'd1;
    localparam logic [1:0] OP_DISPATCH = 2'd2;
    localparam logic [1:0] OP_DELETE   = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_BAD_SLOT = 2'd2;

    typedef struct packed {
        logic [7:0]  handle;
        logic [15:0] delay;
        logic [15:0] period;
        logic [7:0]  pending;
    } t_slot;

    typedef struct packed {
        logic load;
        logic shift;
        logic tick;
        logic dec;
    } t_cell_ctl;

    // low three bits of a slot position
    function automatic logic [2:0] slot_field(input logic [CNT_W-1:0] v);
        logic [CNT_W+2:0] w;
        w = {3'b000, v};
        return w[2:0];
    endfunction

endpackage

[rtl/ptrt_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrt_cell
// One task slot: load, take over the neighbor's slot, tick, or consume a run.
// ----------------------------------------------------------------------------
module ptrt_cell
    import ptrt_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_slot     i_load,
    input  t_slot     i_next,
    output t_slot     o_slot
);

    t_slot r_slot;
    t_slot n_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.load) begin
            n_slot = i_load;
        end else if (i_ctl.shift) begin
            n_slot = i_next;
        end else if (i_ctl.tick) begin
            if (r_slot.delay != 16'd0) begin
                n_slot.delay = r_slot.delay - 16'd1;
            end else begin
                n_slot.delay = r_slot.period;
                // saturate the run count
                if (r_slot.pending != 8'hFF) begin
                    n_slot.pending = r_slot.pending + 8'd1;
                end
            end
        end else if (i_ctl.dec) begin
            n_slot.pending = r_slot.pending - 8'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

    assign o_slot = r_slot;

endmodule

[rtl/periodic_task_release_table_top.sv]
`timescale 1ns / 1ps
// Add and delete give their single result in the cycle after the request; a
// tick gives no result. Dispatch walks one slot per cycle while the result
// side is not stalled; each result is held until the next run is found or
// the walk ends. Throughput: one request per cycle for add, tick and delete
// while the result side is not stalled; a dispatch blocks new requests until
// its walk ends. Reset (synchronous, active low) empties the table.
// ----------------------------------------------------------------------------
// periodic_task_release_table_top
// Time-triggered task release table built as a row of slot cells. The cells
// tick in parallel, shift down toward slot zero on removal, and are scanned
// one per cycle by the dispatch walk while the result side is not stalled.
// ----------------------------------------------------------------------------
module periodic_task_release_table_top
    import ptrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [7:0]  i_task_handle,
    input  logic [15:0] i_first_delay,
    input  logic [15:0] i_repeat_period,
    input  logic [2:0]  i_slot_index,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [2:0]  o_slot,
    output logic [7:0]  o_run_handle,
    output logic        o_run_valid,
    output logic        o_last
);

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_SLOTS);
    localparam logic [NRES_W-1:0] N_CAP   = NRES_W'(RESULT_CAP);

    // control state
    t_state              r_state,      n_state;
    logic [CNT_W-1:0]    r_count,      n_count;
    logic [CNT_W-1:0]    r_idx,        n_idx;
    logic [NRES_W-1:0]   r_nres,       n_nres;
    logic                r_hold_valid, n_hold_valid;
    logic                r_out_valid,  n_out_valid;
    // payload
    logic [2:0]          r_hold_slot,  n_hold_slot;
    logic [7:0]          r_hold_handle, n_hold_handle;
    logic [1:0]          r_status,     n_status;
    logic [2:0]          r_slot,       n_slot;
    logic [7:0]          r_run_handle, n_run_handle;
    logic                r_run_valid,  n_run_valid;
    logic                r_last,       n_last;

    // cell row controls
    logic                load_en;
    logic                tick_en;
    logic                shift_en;
    logic                dec_en;
    logic [CNT_W-1:0]    shift_pos;
    t_slot               load_slot;
    t_slot               cells [MAX_SLOTS];
    t_slot               cur;

    logic                out_free;
    logic                in_accept;
    logic                walk_end;
    logic [CNT_W+2:0]    del_pos_w;
    logic [CNT_W+2:0]    count_w;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE) || !out_free;
    assign in_accept  = i_in_valid && !o_in_stall;

    assign load_slot = '{handle: i_task_handle, delay: i_first_delay,
                         period: i_repeat_period, pending: 8'd0};

    assign del_pos_w = {{CNT_W{1'b0}}, i_slot_index};
    assign count_w   = {3'b000, r_count};

    // slot under the walk; only looked at while r_idx < r_count
    assign cur      = cells[r_idx[IDX_W-1:0]];
    assign walk_end = (r_idx >= r_count) || (r_nres == N_CAP);

    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_idx         = r_idx;
        n_nres        = r_nres;
        n_hold_valid  = r_hold_valid;
        n_hold_slot   = r_hold_slot;
        n_hold_handle = r_hold_handle;
        n_out_valid   = r_out_valid && i_out_stall;
        n_status      = r_status;
        n_slot        = r_slot;
        n_run_handle  = r_run_handle;
        n_run_valid   = r_run_valid;
        n_last        = r_last;
        load_en       = 1'b0;
        tick_en       = 1'b0;
        shift_en      = 1'b0;
        dec_en        = 1'b0;
        shift_pos     = r_idx;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    case (i_operation)
                        OP_ADD: begin
                            n_out_valid  = 1'b1;
                            n_run_handle = 8'd0;
                            n_run_valid  = 1'b0;
                            n_last       = 1'b1;
                            if (r_count < CNT_MAX) begin
                                load_en  = 1'b1;
                                n_count  = r_count + 1'b1;
                                n_status = ST_OK;
                                n_slot   = slot_field(r_count);
                            end else begin
                                n_status = ST_FULL;
                                n_slot   = 3'd0;
                            end
                        end
                        OP_TICK: begin
                            tick_en = 1'b1;
                        end
                        OP_DISPATCH: begin
                            n_state      = S_WALK;
                            n_idx        = '0;
                            n_nres       = '0;
                            n_hold_valid = 1'b0;
                        end
                        OP_DELETE: begin
                            n_out_valid  = 1'b1;
                            n_slot       = i_slot_index;
                            n_run_handle = 8'd0;
                            n_run_valid  = 1'b0;
                            n_last       = 1'b1;
                            if (del_pos_w < count_w) begin
                                shift_en  = 1'b1;
                                shift_pos = del_pos_w[CNT_W-1:0];
                                n_count   = r_count - 1'b1;
                                n_status  = ST_OK;
                            end else begin
                                n_status = ST_BAD_SLOT;
                            end
                        end
                        default: begin
                            tick_en = 1'b0;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (walk_end) begin
                    // flush the held result as the final one
                    if (!r_hold_valid) begin
                        n_state = S_IDLE;
                    end else if (out_free) begin
                        n_out_valid  = 1'b1;
                        n_status     = ST_OK;
                        n_slot       = r_hold_slot;
                        n_run_handle = r_hold_handle;
                        n_run_valid  = 1'b1;
                        n_last       = 1'b1;
                        n_hold_valid = 1'b0;
                        n_state      = S_IDLE;
                    end
                end else if (cur.pending != 8'd0) begin
                    // a run found: release the older held one, hold this one
                    if (!r_hold_valid || out_free) begin
                        if (r_hold_valid) begin
                            n_out_valid  = 1'b1;
                            n_status     = ST_OK;
                            n_slot       = r_hold_slot;
                            n_run_handle = r_hold_handle;
                            n_run_valid  = 1'b1;
                            n_last       = 1'b0;
                        end
                        n_hold_valid  = 1'b1;
                        n_hold_slot   = slot_field(r_idx);
                        n_hold_handle = cur.handle;
                        n_nres        = r_nres + 1'b1;
                        if (cur.period == 16'd0) begin
                            // drop the one-shot slot; revisit this position
                            shift_en  = 1'b1;
                            shift_pos = r_idx;
                            n_count   = r_count - 1'b1;
                        end else begin
                            dec_en = 1'b1;
                            n_idx  = r_idx + 1'b1;
                        end
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_idx        <= '0;
            r_nres       <= '0;
            r_hold_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_idx        <= n_idx;
            r_nres       <= n_nres;
            r_hold_valid <= n_hold_valid;
            r_out_valid  <= n_out_valid;
        end
        r_hold_slot   <= n_hold_slot;
        r_hold_handle <= n_hold_handle;
        r_status      <= n_status;
        r_slot        <= n_slot;
        r_run_handle  <= n_run_handle;
        r_run_valid   <= n_run_valid;
        r_last        <= n_last;
    end

    // row of slot cells; each takes its upper neighbor's slot on a shift
    for (genvar gi = 0; gi < MAX_SLOTS; gi++) begin : g_cell
        localparam logic [CNT_W-1:0] CI = CNT_W'(gi);
        t_cell_ctl ctl;
        t_slot     next_slot;

        assign ctl.load  = load_en && (r_count == CI);
        assign ctl.shift = shift_en && (CI >= shift_pos);
        assign ctl.tick  = tick_en;
        assign ctl.dec   = dec_en && (r_idx == CI);

        if (gi == MAX_SLOTS - 1) begin : g_end
            assign next_slot = '0;
        end else begin : g_mid
            assign next_slot = cells[gi + 1];
        end

        ptrt_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_load (load_slot),
            .i_next (next_slot),
            .o_slot (cells[gi])
        );
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_slot       = r_slot;
    assign o_run_handle = r_run_handle;
    assign o_run_valid  = r_run_valid;
    assign o_last       = r_last;

endmodule

[rtl/ptrt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrt_checker
// Port-level checks on the task release table requests and results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ptrt_checker
    import ptrt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_operation,
    input logic [7:0]  i_task_handle,
    input logic [15:0] i_first_delay,
    input logic [15:0] i_repeat_period,
    input logic [2:0]  i_slot_index,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [2:0]  o_slot,
    input logic [7:0]  o_run_handle,
    input logic        o_run_valid,
    input logic        o_last
);

    logic [44:0] in_bits;
    logic [14:0] out_bits;

    assign in_bits  = {i_operation, i_task_handle, i_first_delay, i_repeat_period,
                       i_slot_index};
    assign out_bits = {o_status, o_slot, o_run_handle, o_run_valid, o_last};

    // a stalled request on the request side holds
    `CHK_NEXT(a_in_hold, i_in_valid && o_in_stall, i_in_valid && $stable(in_bits))

    // a stalled result on the result side holds
    `CHK_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(out_bits))

    // a full table reports slot zero and no run
    `CHK_SAME(a_full_fields, o_out_valid && (o_status == ST_FULL), (o_slot == 3'd0) && !o_run_valid)

    // a run is always reported with an ok status
    `CHK_SAME(a_run_ok, o_out_valid && o_run_valid, o_status == ST_OK)

    // add and delete give exactly one result, so it is the last one
    `CHK_SAME(a_single_last, o_out_valid && !o_run_valid, o_last && (o_run_handle == 8'd0))

endmodule

bind periodic_task_release_table_top ptrt_checker u_ptrt_checker (.*);

[tb/tb_periodic_task_release_table_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_periodic_task_release_table_top
// Self-checking bench for the task release table. Requests go in through the
// valid/stall channel. A bench-side copy of the slot table predicts every
// result, and a checker compares each accepted result field by field against
// the oldest prediction. Directed tests come first: empty table, full table,
// one-shot removal during a dispatch, and pending-count saturation. A random
// mix follows, with both sides idling at random except in one quiet stretch.
// ----------------------------------------------------------------------------
module tb_periodic_task_release_table_top;
    import ptrt_pkg::*;

    typedef struct {
        logic [1:0]  op;
        logic [7:0]  handle;
        logic [15:0] delay;
        logic [15:0] period;
        logic [2:0]  idx;
    } t_request;

    typedef struct {
        logic [1:0] status;
        logic [2:0] slot;
        logic [7:0] handle;
        logic       run;
        logic       last;
    } t_result;

    // DUT inputs start at known values
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_operation = OP_TICK;
    logic [7:0]  i_task_handle = '0;
    logic [15:0] i_first_delay = '0;
    logic [15:0] i_repeat_period = '0;
    logic [2:0]  i_slot_index = '0;
    logic        i_out_stall = 1'b0;

    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [2:0]  o_slot;
    logic [7:0]  o_run_handle;
    logic        o_run_valid;
    logic        o_last;

    // bench copy of the slot table
    logic [7:0]  slot_handle [MAX_SLOTS];
    logic [15:0] slot_delay  [MAX_SLOTS];
    logic [15:0] slot_period [MAX_SLOTS];
    logic [7:0]  slot_runs   [MAX_SLOTS];
    int          slot_used = 0;

    t_result     expected_out[$];
    int          mismatches = 0;
    int          idle_pct = 28;
    int          stall_pct = 28;

    periodic_task_release_table_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_task_handle  (i_task_handle),
        .i_first_delay  (i_first_delay),
        .i_repeat_period(i_repeat_period),
        .i_slot_index   (i_slot_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_slot         (o_slot),
        .o_run_handle   (o_run_handle),
        .o_run_valid    (o_run_valid),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    // Hold the result side at random; stall_pct of zero gives a clean stretch.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------------
    // Table predictor
    // ------------------------------------------------------------------------

    // Drop one slot and shift the later ones down toward slot zero.
    task automatic drop_slot(input int pos);
        for (int i = pos; i + 1 < slot_used; i++) begin
            slot_handle[i] = slot_handle[i + 1];
            slot_delay[i]  = slot_delay[i + 1];
            slot_period[i] = slot_period[i + 1];
            slot_runs[i]   = slot_runs[i + 1];
        end
        slot_used--;
    endtask

    // Update the table for one accepted request and queue the results it owes.
    task automatic apply_request(input t_request r);
        t_result res;
        t_result runs[$];
        int      i;
        res = '{status: ST_OK, slot: 3'd0, handle: 8'd0, run: 1'b0, last: 1'b1};
        case (r.op)
            OP_ADD: begin
                if (slot_used < MAX_SLOTS) begin
                    slot_handle[slot_used] = r.handle;
                    slot_delay[slot_used]  = r.delay;
                    slot_period[slot_used] = r.period;
                    slot_runs[slot_used]   = 8'd0;
                    res.slot = slot_used[2:0];
                    slot_used++;
                end else begin
                    res.status = ST_FULL;
                end
                expected_out.push_back(res);
            end
            OP_TICK: begin
                // count down, or reload and bank one more run (saturating)
                for (i = 0; i < slot_used; i++) begin
                    if (slot_delay[i] != 16'd0) begin
                        slot_delay[i]--;
                    end else begin
                        slot_delay[i] = slot_period[i];
                        if (slot_runs[i] != 8'hFF) slot_runs[i]++;
                    end
                end
            end
            OP_DISPATCH: begin
                // walk in slot order; a removed one-shot pulls the next slot
                // into its place, so revisit the same position
                i = 0;
                while (i < slot_used && runs.size() < RESULT_CAP) begin
                    if (slot_runs[i] != 8'd0) begin
                        res.slot   = i[2:0];
                        res.handle = slot_handle[i];
                        res.run    = 1'b1;
                        res.last   = 1'b0;
                        runs.push_back(res);
                        slot_runs[i]--;
                        if (slot_period[i] == 16'd0) begin
                            drop_slot(i);
                            continue;
                        end
                    end
                    i++;
                end
                if (runs.size() > 0) runs[runs.size() - 1].last = 1'b1;
                foreach (runs[k]) expected_out.push_back(runs[k]);
            end
            default: begin
                res.slot = r.idx;
                if (int'(r.idx) < slot_used) begin
                    drop_slot(int'(r.idx));
                end else begin
                    res.status = ST_BAD_SLOT;
                end
                expected_out.push_back(res);
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------

    // Enter at a rising edge, return at the edge that accepted the request.
    // Stall is sampled at the falling edge, where it has settled.
    task automatic issue_request(input t_request r);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_operation     <= r.op;
        i_task_handle   <= r.handle;
        i_first_delay   <= r.delay;
        i_repeat_period <= r.period;
        i_slot_index    <= r.idx;
        @(negedge i_clk);
        while (o_in_stall) begin
            @(negedge i_clk);
        end
        @(posedge i_clk);
        apply_request(r);
    endtask

    task automatic issue_add(input logic [7:0] h, input logic [15:0] d, input logic [15:0] p);
        issue_request('{op: OP_ADD, handle: h, delay: d, period: p, idx: 3'd0});
    endtask

    task automatic issue_op(input logic [1:0] op, input logic [2:0] idx);
        issue_request('{op: op, handle: 8'd0, delay: 16'd0, period: 16'd0, idx: idx});
    endtask

    // ------------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------------

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Outputs settle after the rising edge; a result that is valid and not
    // stalled at the falling edge is taken at the next rising edge.
    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_out.size() == 0) begin
                $display("%0t: unexpected result, status %0d slot %0d handle %0d run %0d last %0d",
                         $time, o_status, o_slot, o_run_handle, o_run_valid, o_last);
                mismatches++;
            end else begin
                want = expected_out.pop_front();
                check_field("status", 8'(want.status), 8'(o_status));
                check_field("slot", 8'(want.slot), 8'(o_slot));
                check_field("run_handle", want.handle, o_run_handle);
                check_field("run_valid", 8'(want.run), 8'(o_run_valid));
                check_field("last", 8'(want.last), 8'(o_last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Tick and dispatch on an empty table produce nothing; deletes report bad slot.
    task automatic test_empty_table();
        issue_op(OP_TICK, 3'd0);
        issue_op(OP_DISPATCH, 3'd0);
        issue_op(OP_DELETE, 3'd0);
        issue_op(OP_DELETE, 3'd7);
    endtask

    // Fill all slots with extreme field values, overflow once, run, then empty.
    task automatic test_full_table();
        issue_add(8'h00, 16'h0000, 16'h0000);
        issue_add(8'hFF, 16'hFFFF, 16'hFFFF);
        issue_add(8'hA5, 16'h0000, 16'h5555);
        issue_add(8'h5A, 16'h0001, 16'h0002);
        issue_add(8'h0F, 16'hAAAA, 16'hAAAA);
        issue_add(8'hF0, 16'h0000, 16'h0001);
        issue_add(8'h33, 16'h0002, 16'h0000);
        issue_add(8'hCC, 16'h5555, 16'h0003);
        issue_add(8'h77, 16'h0000, 16'h0000);
        issue_op(OP_TICK, 3'd0);
        issue_op(OP_DISPATCH, 3'd0);
        issue_op(OP_TICK, 3'd0);
        issue_op(OP_TICK, 3'd0);
        issue_op(OP_TICK, 3'd0);
        issue_op(OP_DISPATCH, 3'd0);
        issue_op(OP_DELETE, 3'd7);
        issue_op(OP_DELETE, 3'd7);
        while (slot_used > 0) begin
            issue_op(OP_DELETE, 3'd0);
        end
    endtask

    // Two one-shots in a row, each with several banked runs: each runs once,
    // is removed, and the walk picks up the slot that moved into its place.
    task automatic test_one_shot_removal();
        issue_add(8'h11, 16'h0000, 16'h0000);
        issue_add(8'h22, 16'h0000, 16'h0000);
        issue_add(8'h44, 16'h0000, 16'h0001);
        issue_op(OP_TICK, 3'd0);
        issue_op(OP_TICK, 3'd0);
        issue_op(OP_TICK, 3'd0);
        issue_op(OP_DISPATCH, 3'd0);
        issue_op(OP_DISPATCH, 3'd0);
        issue_op(OP_DELETE, 3'd0);
        issue_op(OP_DISPATCH, 3'd0);
    endtask

    // Bank 256 runs on a one-shot slot with zero delay and period; a count
    // that wraps instead of holding at 255 leaves nothing to dispatch.
    task automatic test_run_saturation();
        issue_add(8'h99, 16'h0000, 16'h0000);
        repeat (256) issue_op(OP_TICK, 3'd0);
        issue_op(OP_DISPATCH, 3'd0);
    endtask

    function automatic t_request random_request();
        t_request r;
        int       pick;
        pick     = $urandom_range(99);
        r.op     = (pick < 28) ? OP_ADD : (pick < 60) ? OP_TICK :
                   (pick < 82) ? OP_DISPATCH : OP_DELETE;
        r.handle = 8'($urandom_range(255));
        // mostly short countdowns so slots actually release; a few full-range
        r.delay  = ($urandom_range(9) == 0) ? 16'($urandom_range(65535))
                                            : 16'($urandom_range(3));
        if ($urandom_range(9) == 0) begin
            r.period = 16'($urandom_range(65535));
        end else begin
            r.period = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(4, 1));
        end
        // aim most deletes at occupied slots
        if (slot_used > 0 && $urandom_range(3) != 0) begin
            r.idx = 3'($urandom_range(slot_used - 1));
        end else begin
            r.idx = 3'($urandom_range(7));
        end
        return r;
    endfunction

    task automatic test_random_mix(input int count, input int idle, input int stall);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count) issue_request(random_request());
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        int waited;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_full_table();
        test_one_shot_removal();
        test_run_saturation();
        test_random_mix(30, 28, 28);
        test_random_mix(40, 0, 0);
        test_random_mix(30, 28, 28);

        // drop valid and let the table drain its owed results
        i_in_valid <= 1'b0;
        waited = 0;
        while (expected_out.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_out.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_out.size());
            mismatches++;
        end
        // catch stray results after the last expected one
        repeat (30) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hard stop for a hung handshake.
    initial begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
